>>> rtl/rgb_to_hsv_converter_defines.svh
`ifndef RGB_TO_HSV_CONVERTER_DEFINES_SVH
`define RGB_TO_HSV_CONVERTER_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define RHC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define RHC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/rhc_pkg.sv
package rhc_pkg;

  // Default widths of one colour channel and of the hue fraction.
  localparam int unsigned CHANNEL_BITS = 8;
  localparam int unsigned HUE_BITS     = 16;

endpackage

>>> rtl/rhc_div_pipe.sv
module rhc_div_pipe #(
  parameter int unsigned CHANNEL_BITS = rhc_pkg::CHANNEL_BITS,
  parameter int unsigned HUE_BITS     = rhc_pkg::HUE_BITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [CHANNEL_BITS+2:0] hue_rem_i,
  input  logic [CHANNEL_BITS+2:0] hue_div_i,
  input  logic                    hue_zero_i,
  input  logic [CHANNEL_BITS-1:0] sat_rem_i,
  input  logic [CHANNEL_BITS-1:0] sat_low_i,
  input  logic [CHANNEL_BITS-1:0] sat_div_i,
  input  logic                    sat_zero_i,
  input  logic [CHANNEL_BITS-1:0] value_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [HUE_BITS-1:0]     hue_o,
  output logic [CHANNEL_BITS-1:0] sat_o,
  output logic [CHANNEL_BITS-1:0] value_o
);

  localparam int unsigned C     = CHANNEL_BITS;
  localparam int unsigned H     = HUE_BITS;
  localparam int unsigned HW    = CHANNEL_BITS + 3;
  localparam int unsigned STEPS = (HUE_BITS > CHANNEL_BITS) ? HUE_BITS : CHANNEL_BITS;

  logic          rdy   [STEPS+1];
  logic          v_q   [STEPS];
  logic [HW-1:0] hr_q  [STEPS];
  logic [HW-1:0] hr_d  [STEPS];
  logic [HW-1:0] hd_q  [STEPS];
  logic [H-1:0]  hq_q  [STEPS];
  logic [H-1:0]  hq_d  [STEPS];
  logic          hz_q  [STEPS];
  logic [C-1:0]  sr_q  [STEPS];
  logic [C-1:0]  sr_d  [STEPS];
  logic [C-1:0]  sl_q  [STEPS];
  logic [C-1:0]  sl_d  [STEPS];
  logic [C-1:0]  sd_q  [STEPS];
  logic [C-1:0]  sq_q  [STEPS];
  logic [C-1:0]  sq_d  [STEPS];
  logic          sz_q  [STEPS];
  logic [C-1:0]  val_q [STEPS];

  assign rdy[STEPS] = out_ready_i;
  assign in_ready_o = rdy[0];

  for (genvar k = 0; k < STEPS; k++) begin : g_stage
    logic          pv;
    logic [HW-1:0] phr;
    logic [HW-1:0] phd;
    logic [H-1:0]  phq;
    logic          phz;
    logic [C-1:0]  psr;
    logic [C-1:0]  psl;
    logic [C-1:0]  psd;
    logic [C-1:0]  psq;
    logic          psz;
    logic [C-1:0]  pval;
    logic [HW:0]   ht;
    logic [C:0]    st;

    if (k == 0) begin : g_first
      assign pv   = in_valid_i;
      assign phr  = hue_rem_i;
      assign phd  = hue_div_i;
      assign phq  = '0;
      assign phz  = hue_zero_i;
      assign psr  = sat_rem_i;
      assign psl  = sat_low_i;
      assign psd  = sat_div_i;
      assign psq  = '0;
      assign psz  = sat_zero_i;
      assign pval = value_i;
    end else begin : g_next
      assign pv   = v_q[k-1];
      assign phr  = hr_q[k-1];
      assign phd  = hd_q[k-1];
      assign phq  = hq_q[k-1];
      assign phz  = hz_q[k-1];
      assign psr  = sr_q[k-1];
      assign psl  = sl_q[k-1];
      assign psd  = sd_q[k-1];
      assign psq  = sq_q[k-1];
      assign psz  = sz_q[k-1];
      assign pval = val_q[k-1];
    end

    assign rdy[k] = ~v_q[k] | rdy[k+1];
    assign ht     = {phr, 1'b0};
    assign st     = {psr, psl[C-1]};

    // One restoring division step per stage for each quotient still in progress.
    always_comb begin
      hr_d[k] = phr;
      hq_d[k] = phq;
      sr_d[k] = psr;
      sl_d[k] = psl;
      sq_d[k] = psq;
      if (k < H) begin
        if (ht >= {1'b0, phd}) begin
          hr_d[k] = HW'(ht - {1'b0, phd});
          hq_d[k] = {phq[H-2:0], 1'b1};
        end else begin
          hr_d[k] = ht[HW-1:0];
          hq_d[k] = {phq[H-2:0], 1'b0};
        end
      end
      if (k < C) begin
        sl_d[k] = {psl[C-2:0], 1'b0};
        if (st >= {1'b0, psd}) begin
          sr_d[k] = C'(st - {1'b0, psd});
          sq_d[k] = {psq[C-2:0], 1'b1};
        end else begin
          sr_d[k] = st[C-1:0];
          sq_d[k] = {psq[C-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_q[k] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && pv) begin
        hr_q[k]  <= hr_d[k];
        hd_q[k]  <= phd;
        hq_q[k]  <= hq_d[k];
        hz_q[k]  <= phz;
        sr_q[k]  <= sr_d[k];
        sl_q[k]  <= sl_d[k];
        sd_q[k]  <= psd;
        sq_q[k]  <= sq_d[k];
        sz_q[k]  <= psz;
        val_q[k] <= pval;
      end
    end
  end

  // Zero divisors give all-ones quotients: force grey and black to zero here.
  assign out_valid_o = v_q[STEPS-1];
  assign hue_o       = hz_q[STEPS-1] ? '0 : hq_q[STEPS-1];
  assign sat_o       = sz_q[STEPS-1] ? '0 : sq_q[STEPS-1];
  assign value_o     = val_q[STEPS-1];

endmodule

>>> rtl/rgb_to_hsv_converter.sv
// Throughput: one pixel per cycle while m_axis_tready is high; the hue and saturation
// dividers retire one quotient bit per pipeline stage, so depth follows the wider quotient.
// Reset: rst_ni clears all stage valid bits asynchronously; data registers are not reset.
module rgb_to_hsv_converter #(
  parameter int unsigned CHANNEL_BITS = rhc_pkg::CHANNEL_BITS,
  parameter int unsigned HUE_BITS     = rhc_pkg::HUE_BITS
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        s_axis_tvalid,
  output logic                                        s_axis_tready,
  // red, green, blue from bit 0 up, zero padded to whole bytes
  input  logic [((3*CHANNEL_BITS+7)/8)*8-1:0]         s_axis_tdata,
  output logic                                        m_axis_tvalid,
  input  logic                                        m_axis_tready,
  // hue, saturation, brightness from bit 0 up, zero padded to whole bytes
  output logic [((HUE_BITS+2*CHANNEL_BITS+7)/8)*8-1:0] m_axis_tdata
);

  localparam int unsigned C      = CHANNEL_BITS;
  localparam int unsigned HW     = CHANNEL_BITS + 3;
  localparam int unsigned OUT_W  = ((HUE_BITS + 2*CHANNEL_BITS + 7) / 8) * 8;

  // Input register
  logic         a_v_q;
  logic         a_rdy;
  logic [C-1:0] r_q;
  logic [C-1:0] g_q;
  logic [C-1:0] b_q;

  // Front stage: extremes, sector term and divider operands
  logic          b_v_q;
  logic          b_rdy;
  logic [C-1:0]  hi;
  logic [C-1:0]  lo;
  logic [C-1:0]  d;
  logic [HW-1:0] d_x;
  logic [HW-1:0] d6;
  logic [HW-1:0] term;
  logic [2*C-1:0] sat_num;
  logic [HW-1:0] term_q;
  logic [HW-1:0] d6_q;
  logic          hz_q;
  logic [C-1:0]  sat_hi_q;
  logic [C-1:0]  sat_lo_q;
  logic [C-1:0]  max_q;
  logic          sz_q;

  logic                lane_ready;
  logic [HUE_BITS-1:0] hue;
  logic [C-1:0]        sat;
  logic [C-1:0]        value;

  assign a_rdy         = ~a_v_q | b_rdy;
  assign b_rdy         = ~b_v_q | lane_ready;
  assign s_axis_tready = a_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
    end else begin
      if (a_rdy) begin
        a_v_q <= s_axis_tvalid;
      end
      if (b_rdy) begin
        b_v_q <= a_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_rdy && s_axis_tvalid) begin
      r_q <= s_axis_tdata[C-1:0];
      g_q <= s_axis_tdata[2*C-1:C];
      b_q <= s_axis_tdata[3*C-1:2*C];
    end
  end

  always_comb begin
    hi = r_q;
    if (g_q > hi) hi = g_q;
    if (b_q > hi) hi = b_q;
    lo = r_q;
    if (g_q < lo) lo = g_q;
    if (b_q < lo) lo = b_q;
    d       = hi - lo;
    d_x     = HW'(d);
    d6      = HW'((d_x << 2) + (d_x << 1));
    sat_num = (2*C)'({d, {C{1'b0}}} - {{C{1'b0}}, d});
    // Ties go to red, then green; add the offset first so the term never wraps
    if (hi == r_q) begin
      if (g_q >= b_q) begin
        term = HW'(g_q) - HW'(b_q);
      end else begin
        term = d6 + HW'(g_q) - HW'(b_q);
      end
    end else if (hi == g_q) begin
      term = (d_x << 1) + HW'(b_q) - HW'(r_q);
    end else begin
      term = (d_x << 2) + HW'(r_q) - HW'(g_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_rdy && a_v_q) begin
      term_q   <= term;
      d6_q     <= d6;
      hz_q     <= (d == '0);
      sat_hi_q <= sat_num[2*C-1:C];
      sat_lo_q <= sat_num[C-1:0];
      max_q    <= hi;
      sz_q     <= (hi == '0);
    end
  end

  rhc_div_pipe #(
    .CHANNEL_BITS(CHANNEL_BITS),
    .HUE_BITS    (HUE_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (b_v_q),
    .in_ready_o (lane_ready),
    .hue_rem_i  (term_q),
    .hue_div_i  (d6_q),
    .hue_zero_i (hz_q),
    .sat_rem_i  (sat_hi_q),
    .sat_low_i  (sat_lo_q),
    .sat_div_i  (max_q),
    .sat_zero_i (sz_q),
    .value_i    (max_q),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .hue_o      (hue),
    .sat_o      (sat),
    .value_o    (value)
  );

  assign m_axis_tdata = OUT_W'({value, sat, hue});

endmodule

>>> rtl/rgb_to_hsv_converter_checker.sv
`include "rgb_to_hsv_converter_defines.svh"

module rgb_to_hsv_converter_checker #(
  parameter int unsigned CHANNEL_BITS = rhc_pkg::CHANNEL_BITS,
  parameter int unsigned HUE_BITS     = rhc_pkg::HUE_BITS
) (
  input logic                                        clk_i,
  input logic                                        rst_ni,
  input logic                                        s_axis_tvalid,
  input logic                                        s_axis_tready,
  input logic [((3*CHANNEL_BITS+7)/8)*8-1:0]         s_axis_tdata,
  input logic                                        m_axis_tvalid,
  input logic                                        m_axis_tready,
  input logic [((HUE_BITS+2*CHANNEL_BITS+7)/8)*8-1:0] m_axis_tdata
);

  localparam int unsigned C     = CHANNEL_BITS;
  localparam int unsigned H     = HUE_BITS;
  localparam int unsigned STEPS = (HUE_BITS > CHANNEL_BITS) ? HUE_BITS : CHANNEL_BITS;
  localparam int unsigned CW    = $clog2(STEPS + 4) + 1;

  logic          in_beat;
  logic          out_beat;
  logic [CW-1:0] cnt_d;
  logic [CW-1:0] cnt_q;
  logic [H-1:0]  hue;
  logic [C-1:0]  sat;
  logic [C-1:0]  value;

  assign in_beat  = s_axis_tvalid & s_axis_tready;
  assign out_beat = m_axis_tvalid & m_axis_tready;
  assign hue      = m_axis_tdata[H-1:0];
  assign sat      = m_axis_tdata[H+C-1:H];
  assign value    = m_axis_tdata[H+2*C-1:H+C];

  // Track pixels in flight between the two ports.
  always_comb begin
    cnt_d = cnt_q;
    if (in_beat && !out_beat) begin
      cnt_d = cnt_q + CW'(1);
    end else if (out_beat && !in_beat) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  `RHC_ASSERT_NOW(a_no_spurious_out, m_axis_tvalid, cnt_q != '0, "output beat without input")
  `RHC_ASSERT_NOW(a_black_is_zero, m_axis_tvalid && value == '0, sat == '0 && hue == '0, "black pixel not zero")
  `RHC_ASSERT_NOW(a_grey_hue_zero, m_axis_tvalid && sat == '0, hue == '0, "grey pixel has hue")
  `RHC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled beat changed")

endmodule

bind rgb_to_hsv_converter rgb_to_hsv_converter_checker #(
  .CHANNEL_BITS(CHANNEL_BITS),
  .HUE_BITS    (HUE_BITS)
) u_checker (.*);

>>> test/rgb_to_hsv_checker.sv
`timescale 1ns / 100ps

module rgb_to_hsv_checker #(
  parameter int unsigned CHANNEL_BITS = rhc_pkg::CHANNEL_BITS,
  parameter int unsigned HUE_BITS     = rhc_pkg::HUE_BITS
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         s_axis_tvalid,
  input  logic                                         s_axis_tready,
  // red, green, blue from bit 0 up, zero padded to whole bytes
  input  logic [((3*CHANNEL_BITS+7)/8)*8-1:0]          s_axis_tdata,
  input  logic                                         m_axis_tvalid,
  input  logic                                         m_axis_tready,
  // hue, saturation, brightness from bit 0 up, zero padded to whole bytes
  input  logic [((HUE_BITS+2*CHANNEL_BITS+7)/8)*8-1:0] m_axis_tdata,
  output int unsigned                                  error_count_o,
  output int unsigned                                  pending_o
);

  localparam int unsigned CB = CHANNEL_BITS;
  localparam int unsigned HB = HUE_BITS;

  typedef struct packed {
    logic [HB-1:0] hue;
    logic [CB-1:0] sat;
    logic [CB-1:0] val;
  } hsv_t;

  typedef struct {
    hsv_t            hsv;
    logic [3*CB-1:0] rgb;
  } pixel_result_t;

  pixel_result_t expected_hsv[$];
  pixel_result_t want;
  hsv_t          got;
  int unsigned   mismatches = 0;
  int unsigned   in_flight  = 0;

  assign error_count_o = mismatches;
  assign pending_o     = in_flight;

  function automatic hsv_t hsv_of(logic [CB-1:0] r, logic [CB-1:0] g, logic [CB-1:0] b);
    logic [63:0] rw, gw, bw, hi, lo, d, term;
    hsv_t res;
    rw = r;
    gw = g;
    bw = b;
    hi = rw;
    if (gw > hi) hi = gw;
    if (bw > hi) hi = bw;
    lo = rw;
    if (gw < lo) lo = gw;
    if (bw < lo) lo = bw;
    d = hi - lo;
    res.val = hi[CB-1:0];
    res.sat = '0;
    res.hue = '0;
    if (hi != 0) res.sat = CB'((d * ((64'd1 << CB) - 1)) / hi);
    if (d != 0) begin
      // ties resolve to red first, then green; offsets go in before the subtraction
      if (hi == rw) term = (gw >= bw) ? gw - bw : 6 * d + gw - bw;
      else if (hi == gw) term = 2 * d + bw - rw;
      else term = 4 * d + rw - gw;
      res.hue = HB'((term << HB) / (6 * d));
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] seen, logic [63:0] wanted,
                                 logic [3*CB-1:0] rgb);
    $display("%0t: %s mismatch, rgb(b,g,r)=%h: got %0h expected %0h",
             $realtime, what, rgb, seen, wanted);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_hsv.delete();
      in_flight <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        want.rgb = s_axis_tdata[3*CB-1:0];
        want.hsv = hsv_of(s_axis_tdata[CB-1:0], s_axis_tdata[2*CB-1:CB],
                          s_axis_tdata[3*CB-1:2*CB]);
        expected_hsv.insert(expected_hsv.size(), want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.hue = m_axis_tdata[HB-1:0];
        got.sat = m_axis_tdata[HB+CB-1:HB];
        got.val = m_axis_tdata[HB+2*CB-1:HB+CB];
        if (expected_hsv.size() == 0) begin
          report_mismatch("unexpected beat", 64'(m_axis_tdata), '0, '0);
        end else begin
          want = expected_hsv.pop_front();
          if (got.hue !== want.hsv.hue)
            report_mismatch("hue", got.hue, want.hsv.hue, want.rgb);
          if (got.sat !== want.hsv.sat)
            report_mismatch("saturation", got.sat, want.hsv.sat, want.rgb);
          if (got.val !== want.hsv.val)
            report_mismatch("brightness", got.val, want.hsv.val, want.rgb);
        end
      end
      in_flight <= expected_hsv.size();
    end
  end

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int unsigned CHANNEL_BITS  = rhc_pkg::CHANNEL_BITS;
  localparam int unsigned HUE_BITS      = rhc_pkg::HUE_BITS;
  localparam int unsigned IN_W          = ((3*CHANNEL_BITS+7)/8)*8;
  localparam int unsigned OUT_W         = ((HUE_BITS+2*CHANNEL_BITS+7)/8)*8;
  localparam int unsigned LATENCY       =
    ((HUE_BITS > CHANNEL_BITS) ? HUE_BITS : CHANNEL_BITS) + 2;
  localparam int unsigned RANDOM_PIXELS = 500;
  localparam int unsigned HOLD_START    = 150;
  localparam int unsigned HOLD_ITEMS    = 60;
  localparam int unsigned DRAIN_AT      = 300;
  localparam int unsigned QUIET_ITEMS   = 80;
  localparam int unsigned LONG_HOLD     = 100;
  localparam int unsigned STALL_LIMIT   = 2000;

  typedef logic [CHANNEL_BITS-1:0] chan_t;
  localparam chan_t FULL = '1;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  // red, green, blue from bit 0 up, zero padded to whole bytes
  logic [IN_W-1:0]  s_axis_tdata  = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  // hue, saturation, brightness from bit 0 up, zero padded to whole bytes
  logic [OUT_W-1:0] m_axis_tdata;

  int unsigned error_count;
  int unsigned pending_results;
  bit          no_idle       = 1'b0;
  bit          long_hold_req = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  rgb_to_hsv_converter u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  rgb_to_hsv_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .error_count_o (error_count),
    .pending_o     (pending_results)
  );

  function automatic chan_t any_chan();
    return chan_t'($urandom_range(0, int'(FULL)));
  endfunction

  function automatic int unsigned sender_gap();
    if (no_idle || $urandom_range(0, 5) != 0) return 0;
    return $urandom_range(1, 18);
  endfunction

  task automatic push_pixel(chan_t r, chan_t g, chan_t b, int unsigned gap);
    logic [IN_W-1:0] beat;
    beat = '0;
    beat[3*CHANNEL_BITS-1:0] = {b, g, r};
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= beat;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  initial begin : stimulus
    chan_t r, g, b, v;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    push_pixel('0, '0, '0, sender_gap());              // black
    push_pixel(FULL, FULL, FULL, sender_gap());        // white
    push_pixel(8'd128, 8'd128, 8'd128, sender_gap());  // grey
    push_pixel(8'd1, 8'd1, 8'd1, sender_gap());
    push_pixel(FULL, '0, '0, sender_gap());
    push_pixel('0, FULL, '0, sender_gap());
    push_pixel('0, '0, FULL, sender_gap());
    push_pixel(FULL, FULL, '0, sender_gap());          // red and green tie
    push_pixel('0, FULL, FULL, sender_gap());          // green and blue tie
    push_pixel(FULL, '0, FULL, sender_gap());          // red and blue tie
    push_pixel(FULL, '0, 8'd1, sender_gap());          // red sector, negative hue wraps to just below a full turn
    push_pixel(FULL, 8'd1, '0, sender_gap());
    push_pixel(8'd1, '0, '0, sender_gap());
    push_pixel('0, 8'd1, '0, sender_gap());
    push_pixel('0, '0, 8'd1, sender_gap());
    push_pixel(8'd1, '0, 8'd1, sender_gap());
    push_pixel(FULL, 8'd254, 8'd254, sender_gap());
    push_pixel(8'd254, FULL, FULL, sender_gap());
    push_pixel(8'd170, 8'd85, '0, sender_gap());
    push_pixel(8'd200, 8'd100, 8'd150, sender_gap());
    push_pixel(8'd10, 8'd200, 8'd100, sender_gap());
    push_pixel(8'd50, 8'd60, 8'd250, sender_gap());
    push_pixel(8'h55, 8'hAA, 8'h55, sender_gap());

    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      if (i == HOLD_START) long_hold_req = 1'b1;
      if (i == DRAIN_AT) begin
        // hold off until the pipeline has delivered everything
        s_axis_tvalid <= 1'b0;
        do @(posedge clk_i); while (pending_results != 0);
      end
      if (i == RANDOM_PIXELS - QUIET_ITEMS) no_idle = 1'b1;
      v = any_chan();
      r = any_chan();
      g = any_chan();
      b = any_chan();
      case ($urandom_range(0, 11))
        0: begin r = v; g = v; b = v; end
        1: begin r = v; g = v; b = chan_t'($urandom_range(0, int'(v))); end
        2: begin g = v; b = v; r = chan_t'($urandom_range(0, int'(v))); end
        3: begin r = v; b = v; g = chan_t'($urandom_range(0, int'(v))); end
        4: begin
          r = chan_t'($urandom_range(0, 3));
          g = chan_t'($urandom_range(0, 3));
          b = chan_t'($urandom_range(0, 3));
        end
        5: begin
          if ($urandom_range(0, 1)) r = $urandom_range(0, 1) ? FULL : '0;
          if ($urandom_range(0, 1)) g = $urandom_range(0, 1) ? FULL : '0;
          if ($urandom_range(0, 1)) b = $urandom_range(0, 1) ? FULL : '0;
        end
        default: ;
      endcase
      push_pixel(r, g, b,
                 (i >= HOLD_START && i < HOLD_START + HOLD_ITEMS) ? 0 : sender_gap());
    end

    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results != 0);
    repeat (LATENCY + 8) @(posedge clk_i);
    if (error_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : result_sink
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (long_hold_req) begin
        // stall the output long enough for the pipeline to back up into the input
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        long_hold_req = 1'b0;
      end else if (!no_idle && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk_i);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $realtime, STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

endmodule

>>> files.f
+incdir+rtl
rtl/rhc_pkg.sv
rtl/rhc_div_pipe.sv
rtl/rgb_to_hsv_converter.sv
rtl/rgb_to_hsv_converter_checker.sv
test/rgb_to_hsv_checker.sv
test/tb.sv
